// ----- hw/rtl/pli_pkg.sv -----
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Shared types and codes for the breakpoint table, sequencer and the
// shared multiply/divide unit.
// ----------------------------------------------------------------------------
package pli_pkg;

   // request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // fixed port widths
   localparam int INDEX_BITS = 8;
   localparam int CSR_BITS   = 9;

   // sequencer states, one-hot
   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_CHK_FIRST = 10'b00_0000_0010,
      S_CHK_LAST  = 10'b00_0000_0100,
      S_SEARCH    = 10'b00_0000_1000,
      S_PROBE     = 10'b00_0001_0000,
      S_LAST_Y    = 10'b00_0010_0000,
      S_GET_HI    = 10'b00_0100_0000,
      S_GET_LO    = 10'b00_1000_0000,
      S_MUL       = 10'b01_0000_0000,
      S_DIV       = 10'b10_0000_0000
   } state_type;

   // shared unit operations
   typedef enum logic [0:0] {
      MDU_MUL = 1'b0,
      MDU_DIV = 1'b1
   } mdu_op_type;

   // command from the sequencer to the shared unit
   typedef struct packed {
      logic       start;
      mdu_op_type op;
   } mdu_ctrl_type;

endpackage

// ----- hw/rtl/pli_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/pli_mdu.sv -----
// ----------------------------------------------------------------------------
// Shared multiply/divide unit
// One add/subtract datapath over a hi/lo register pair. Multiply is
// shift-add, one multiplier bit per cycle; divide is restoring, one
// quotient bit per cycle, working on the product left in hi/lo.
// ----------------------------------------------------------------------------
module pli_mdu #(
   parameter int WIDTH = 33
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pli_pkg::mdu_ctrl_type ctrl,
   input  logic [WIDTH-1:0]      mul_a,
   input  logic [WIDTH-1:0]      mul_b,
   input  logic [WIDTH-1:0]      div_d,
   output logic                  done,
   output logic [WIDTH-1:0]      quotient
);

   localparam int CNTW = $clog2(WIDTH + 1);

   logic [WIDTH:0]       hi_ff, hi_in;
   logic [WIDTH-1:0]     lo_ff, lo_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   pli_pkg::mdu_op_type  op_ff, op_in;

   logic [WIDTH:0]       rem;
   logic [WIDTH+1:0]     add_a, add_b, sum;
   logic                 cin, ge;

   // shared adder: accumulate for multiply, trial subtract for divide
   always_comb begin
      rem = {hi_ff[WIDTH-1:0], lo_ff[WIDTH-1]};
      if (op_ff == pli_pkg::MDU_MUL) begin
         add_a = {1'b0, hi_ff};
         add_b = {2'b00, mul_a & {WIDTH{lo_ff[0]}}};
         cin   = 1'b0;
      end else begin
         add_a = {1'b0, rem};
         add_b = ~{2'b00, div_d};
         cin   = 1'b1;
      end
      sum = add_a + add_b + {{(WIDTH+1){1'b0}}, cin};
      ge  = ~sum[WIDTH+1];
   end

   // step control
   always_comb begin
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      op_in   = op_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         op_in  = ctrl.op;
         run_in = 1'b1;
         cnt_in = CNTW'(WIDTH);
         if (ctrl.op == pli_pkg::MDU_MUL) begin
            hi_in = '0;
            lo_in = mul_b;
         end
      end else if (run_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
         if (op_ff == pli_pkg::MDU_MUL) begin
            hi_in = {1'b0, sum[WIDTH:1]};
            lo_in = {sum[0], lo_ff[WIDTH-1:1]};
         end else begin
            hi_in = ge ? sum[WIDTH:0] : rem;
            lo_in = {lo_ff[WIDTH-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= pli_pkg::MDU_MUL;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done     = done_ff;
   assign quotient = lo_ff;

   // a new operation never lands on one still running
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> !run_ff)
      else $error("shared unit started while running");

endmodule

// ----- hw/rtl/piecewise_linear_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// Piecewise linear interpolator
// Breakpoint table with binary search and fixed-point interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive start with req_kind, req_point_index, req_x_value
//   and req_y_value; the request is taken at a clock edge with start high and
//   busy low. A load request writes one breakpoint in that cycle and leaves
//   busy low, so loads stream at one per cycle. A query on a nonempty table
//   raises busy until its response is issued; an empty table does not.
//   Response channel: rsp_strobe is high for exactly one cycle with
//   rsp_y_result and rsp_status; the receiver cannot stall and must take it.
//   CSR: csr_write_enable writes point_count, saturated to MAX_POINTS; write
//   it only while busy is low.
//   Query flow: an empty table answers from the idle state; an x outside
//   the end breakpoints is answered from the first or last range check. A
//   full interpolation runs a binary search of at most log2(point_count) + 1
//   probes, then reads both segment ends, multiplies and divides. Each probe
//   costs one table read plus a compare; the multiply and the divide each
//   run one bit per cycle on the single shared add/subtract unit. A new
//   request may be taken in the cycle rsp_strobe is high.
//   Reset clears point_count and the sequencer; table contents are kept
//   and are undefined until loaded.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_unit #(
   parameter int MAX_POINTS = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [pli_pkg::INDEX_BITS-1:0]      req_point_index,
   input  logic signed [VALUE_BITS-1:0]        req_x_value,
   input  logic signed [VALUE_BITS-1:0]        req_y_value,
   input  logic                                csr_write_enable,
   input  logic [pli_pkg::CSR_BITS-1:0]        csr_write_data,
   output logic                                rsp_strobe,
   output logic signed [VALUE_BITS-1:0]        rsp_y_result,
   output logic [1:0]                          rsp_status
);

   localparam int V  = VALUE_BITS;
   localparam int W  = VALUE_BITS + 1;
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int IW = CW + 1;
   localparam logic signed [IW-1:0] IDX_ONE = IW'(1);
   localparam logic signed [V-1:0]  VMAX = {1'b0, {(V-1){1'b1}}};
   localparam logic signed [V-1:0]  VMIN = {1'b1, {(V-1){1'b0}}};

   pli_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic signed [V-1:0]    x_ff, x_in;
   logic signed [IW-1:0]   lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic signed [V-1:0]    xh_ff, xh_in, yh_ff, yh_in, base_ff, base_in;
   logic [W-1:0]           mag_ff, mag_in, span_ff, span_in;
   logic                   neg_ff, neg_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic signed [V-1:0]    rsp_y_ff, rsp_y_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic signed [V-1:0]    x_rd, y_rd;
   logic [CW-1:0]          cnt_last;
   logic signed [IW-1:0]   n_w, diff_w, mid_w, lo_m1;
   logic signed [V:0]      span_w, dx_w, dy_w;
   logic [W-1:0]           mag_w;
   logic signed [V+1:0]    res_w;
   logic signed [V-1:0]    sat_w;
   logic                   fin;
   logic [1:0]             fin_status;
   logic signed [V-1:0]    fin_y;

   pli_pkg::mdu_ctrl_type  mdu_ctrl;
   logic                   mdu_done;
   logic [W-1:0]           mdu_q;

   assign busy   = (state_ff != pli_pkg::S_IDLE);
   assign accept = start && !busy;

   // write a breakpoint on an in-range load request
   assign wr_en   = accept && (req_kind == pli_pkg::KIND_LOAD) &&
                    (int'(req_point_index) < MAX_POINTS);
   assign wr_addr = AW'(req_point_index);

   pli_ram #(.WIDTH(V), .DEPTH(MAX_POINTS)) u_x_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_x_value),
      .rd_addr (rd_addr),
      .rd_data (x_rd)
   );

   pli_ram #(.WIDTH(V), .DEPTH(MAX_POINTS)) u_y_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_y_value),
      .rd_addr (rd_addr),
      .rd_data (y_rd)
   );

   pli_mdu #(.WIDTH(W)) u_mdu (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mdu_ctrl),
      .mul_a    (mag_ff),
      .mul_b    (dx_w),
      .div_d    (span_ff),
      .done     (mdu_done),
      .quotient (mdu_q)
   );

   // clamp the point count write
   always_comb begin
      count_in = count_ff;
      if (csr_write_enable) begin
         if (int'(csr_write_data) > MAX_POINTS) begin
            count_in = CW'(MAX_POINTS);
         end else begin
            count_in = CW'(csr_write_data);
         end
      end
   end

   // search index arithmetic
   always_comb begin
      cnt_last = count_ff - 1'b1;
      n_w      = $signed({1'b0, count_ff});
      diff_w   = hi_ff - lo_ff;
      mid_w    = lo_ff + (diff_w >>> 1);
      lo_m1    = lo_ff - IDX_ONE;
   end

   // segment deltas from the two neighboring breakpoints
   always_comb begin
      span_w = {xh_ff[V-1], xh_ff} - {x_rd[V-1], x_rd};
      dx_w   = {x_ff[V-1], x_ff} - {x_rd[V-1], x_rd};
      dy_w   = {yh_ff[V-1], yh_ff} - {y_rd[V-1], y_rd};
      mag_w  = dy_w[V] ? W'(-dy_w) : W'(dy_w);
   end

   // apply the scaled delta and saturate
   always_comb begin
      if (neg_ff) begin
         res_w = {{2{base_ff[V-1]}}, base_ff} - {1'b0, mdu_q};
      end else begin
         res_w = {{2{base_ff[V-1]}}, base_ff} + {1'b0, mdu_q};
      end
      if ((res_w[V+1:V-1] == 3'b000) || (res_w[V+1:V-1] == 3'b111)) begin
         sat_w = res_w[V-1:0];
      end else if (res_w[V+1]) begin
         sat_w = VMIN;
      end else begin
         sat_w = VMAX;
      end
   end

   // query sequencer
   always_comb begin
      state_in   = state_ff;
      x_in       = x_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      xh_in      = xh_ff;
      yh_in      = yh_ff;
      base_in    = base_ff;
      mag_in     = mag_ff;
      span_in    = span_ff;
      neg_in     = neg_ff;
      rd_addr    = '0;
      mdu_ctrl   = '{start: 1'b0, op: pli_pkg::MDU_MUL};
      fin        = 1'b0;
      fin_status = pli_pkg::ST_OK;
      fin_y      = '0;
      case (state_ff)
         pli_pkg::S_IDLE: begin
            // table entry 0 is read here for the first range check
            if (accept && (req_kind == pli_pkg::KIND_QUERY)) begin
               x_in = req_x_value;
               if (count_ff == '0) begin
                  fin        = 1'b1;
                  fin_status = pli_pkg::ST_EMPTY;
               end else begin
                  state_in = pli_pkg::S_CHK_FIRST;
               end
            end
         end
         pli_pkg::S_CHK_FIRST: begin
            rd_addr = AW'(cnt_last);
            if (x_ff < x_rd) begin
               fin        = 1'b1;
               fin_status = pli_pkg::ST_RANGE;
            end else begin
               state_in = pli_pkg::S_CHK_LAST;
            end
         end
         pli_pkg::S_CHK_LAST: begin
            if (x_ff > x_rd) begin
               fin        = 1'b1;
               fin_status = pli_pkg::ST_RANGE;
            end else begin
               lo_in    = '0;
               hi_in    = $signed({1'b0, cnt_last});
               state_in = pli_pkg::S_SEARCH;
            end
         end
         pli_pkg::S_SEARCH: begin
            if (lo_ff <= hi_ff) begin
               rd_addr  = AW'(mid_w);
               mid_in   = mid_w;
               state_in = pli_pkg::S_PROBE;
            end else if (lo_ff >= n_w) begin
               // x sits on the last breakpoint
               rd_addr  = AW'(cnt_last);
               state_in = pli_pkg::S_LAST_Y;
            end else if (lo_ff == '0) begin
               fin        = 1'b1;
               fin_status = pli_pkg::ST_RANGE;
            end else begin
               rd_addr  = AW'(lo_ff);
               state_in = pli_pkg::S_GET_HI;
            end
         end
         pli_pkg::S_PROBE: begin
            if (x_ff < x_rd) begin
               hi_in = mid_ff - IDX_ONE;
            end else begin
               lo_in = mid_ff + IDX_ONE;
            end
            state_in = pli_pkg::S_SEARCH;
         end
         pli_pkg::S_LAST_Y: begin
            fin   = 1'b1;
            fin_y = y_rd;
         end
         pli_pkg::S_GET_HI: begin
            xh_in    = x_rd;
            yh_in    = y_rd;
            rd_addr  = AW'(lo_m1);
            state_in = pli_pkg::S_GET_LO;
         end
         pli_pkg::S_GET_LO: begin
            base_in = y_rd;
            neg_in  = dy_w[V];
            mag_in  = mag_w;
            span_in = W'(span_w);
            if ((span_w <= 0) || (dx_w < 0)) begin
               fin        = 1'b1;
               fin_status = pli_pkg::ST_RANGE;
            end else begin
               mdu_ctrl = '{start: 1'b1, op: pli_pkg::MDU_MUL};
               state_in = pli_pkg::S_MUL;
            end
         end
         pli_pkg::S_MUL: begin
            // chain the divide onto the finished product
            if (mdu_done) begin
               mdu_ctrl = '{start: 1'b1, op: pli_pkg::MDU_DIV};
               state_in = pli_pkg::S_DIV;
            end
         end
         pli_pkg::S_DIV: begin
            if (mdu_done) begin
               fin   = 1'b1;
               fin_y = sat_w;
            end
         end
         default: begin
            state_in = pli_pkg::S_IDLE;
         end
      endcase

      // issue the response and drop back to idle
      rsp_strobe_in = fin;
      rsp_status_in = rsp_status_ff;
      rsp_y_in      = rsp_y_ff;
      if (fin) begin
         rsp_status_in = fin_status;
         rsp_y_in      = fin_y;
         state_in      = pli_pkg::S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pli_pkg::S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      x_ff          <= x_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      xh_ff         <= xh_in;
      yh_ff         <= yh_in;
      base_ff       <= base_in;
      mag_ff        <= mag_in;
      span_ff       <= span_in;
      neg_ff        <= neg_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_y_result = rsp_y_ff;
   assign rsp_status   = rsp_status_ff;

   // a query either starts the sequencer or answers at once
   a_query_taken: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == pli_pkg::KIND_QUERY)) |=> (busy || rsp_strobe))
      else $error("query request dropped");

   // busy rises only out of an accepted request
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy raised without a request");

   // a probe always lands inside the active table
   a_probe_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pli_pkg::S_PROBE) |-> ((mid_ff >= 0) && (mid_ff < n_w)))
      else $error("search probe outside the table");

   // error responses carry a zero value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != pli_pkg::ST_OK)) |-> (rsp_y_result == '0))
      else $error("nonzero value on an error response");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear interpolator testbench
// Drives load and query requests through the start/busy port. The same
// requests go to a local breakpoint table model that predicts the responses
// that directed rows do not give. Every response is compared with the oldest
// pending prediction. A short table of directed requests runs first. Random
// tables and queries follow, under several sender idle patterns.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int     MAX_POINTS         = 256;
   localparam int     VALUE_BITS         = 32;
   localparam longint VALUE_MAX          = (longint'(1) << (VALUE_BITS - 1)) - 1;
   localparam longint VALUE_MIN          = -VALUE_MAX - 1;
   localparam longint VALUE_SPAN         = longint'(1) << VALUE_BITS;
   localparam int     TARGET_REQUESTS    = 550;
   localparam int     LOAD_SETTLE_CYCLES = 4;
   localparam int     DRAIN_CYCLES       = 100;
   localparam int     STALL_LIMIT        = 3000;
   localparam int     DIRECTED_ROWS      = 27;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] y;
      logic [1:0]                   status;
   } lookup_result_type;

   typedef enum logic {ROW_REQUEST, ROW_COUNT} row_action_type;

   typedef struct packed {
      row_action_type                 action;
      logic [pli_pkg::CSR_BITS-1:0]   count;
      logic                           kind;
      logic [pli_pkg::INDEX_BITS-1:0] index;
      logic signed [VALUE_BITS-1:0]   x;
      logic signed [VALUE_BITS-1:0]   y;
      logic                           typed;
      logic signed [VALUE_BITS-1:0]   want_y;
      logic [1:0]                     want_status;
   } stim_row_type;

   logic                           clock            = 1'b0;
   logic                           reset            = 1'b1;
   logic                           start            = 1'b0;
   logic                           busy;
   logic                           req_kind         = pli_pkg::KIND_LOAD;
   logic [pli_pkg::INDEX_BITS-1:0] req_point_index  = '0;
   logic signed [VALUE_BITS-1:0]   req_x_value      = '0;
   logic signed [VALUE_BITS-1:0]   req_y_value      = '0;
   logic                           csr_write_enable = 1'b0;
   logic [pli_pkg::CSR_BITS-1:0]   csr_write_data   = '0;
   logic                           rsp_strobe;
   logic signed [VALUE_BITS-1:0]   rsp_y_result;
   logic [1:0]                     rsp_status;

   // local copy of the breakpoint table and point count
   logic signed [VALUE_BITS-1:0] bp_x [0:MAX_POINTS-1];
   logic signed [VALUE_BITS-1:0] bp_y [0:MAX_POINTS-1];
   int                           bp_count = 0;

   lookup_result_type pending_results [$];
   int                requests_taken   = 0;
   int                error_count      = 0;
   int                sender_idle_pct  = 0;
   int                stall_cycles     = 0;

   // directed requests: empty table, extremes, last breakpoint, out of range,
   // single point, unsorted table
   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{ROW_COUNT,   9'd0, pli_pkg::KIND_LOAD,  8'd0,   32'sh0,         32'sh0,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'sh0,         32'sh0,
        1'b1, 32'sh0,         pli_pkg::ST_EMPTY},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'sh8000_0000, 32'sh0,
        1'b1, 32'sh0,         pli_pkg::ST_EMPTY},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd255, 32'sh7FFF_FFFF, 32'sh8000_0000,
        1'b1, 32'sh0,         pli_pkg::ST_EMPTY},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_LOAD,  8'd0,   32'sh8000_0000, 32'sh7FFF_FFFF,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_LOAD,  8'd1,   32'sh0,         32'sh8000_0000,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_LOAD,  8'd2,   32'sh0001_0000, 32'sh0001_0000,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_LOAD,  8'd3,   32'sh7FFF_FFFF, 32'shFFFF_FFFF,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_LOAD,  8'd255, 32'sh7FFF_FFFF, 32'shFFFF_FFFF,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_COUNT,   9'd4, pli_pkg::KIND_LOAD,  8'd0,   32'sh0,         32'sh0,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'sh8000_0000, 32'sh0,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'sh7FFF_FFFF, 32'sh0,
        1'b1, 32'shFFFF_FFFF, pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'shFFFF_FFFF, 32'sh0,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'sh0000_8000, 32'sh0,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'sh4000_0000, 32'sh0,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_COUNT,   9'd3, pli_pkg::KIND_LOAD,  8'd0,   32'sh0,         32'sh0,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'sh0001_0001, 32'sh0,
        1'b1, 32'sh0,         pli_pkg::ST_RANGE},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'sh7FFF_FFFF, 32'sh0,
        1'b1, 32'sh0,         pli_pkg::ST_RANGE},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'sh0001_0000, 32'sh0,
        1'b1, 32'sh0001_0000, pli_pkg::ST_OK},
      '{ROW_COUNT,   9'd1, pli_pkg::KIND_LOAD,  8'd0,   32'sh0,         32'sh0,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'sh8000_0000, 32'sh0,
        1'b1, 32'sh7FFF_FFFF, pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'sh8000_0001, 32'sh0,
        1'b1, 32'sh0,         pli_pkg::ST_RANGE},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_LOAD,  8'd1,   32'sh0003_0000, 32'sh0000_0005,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_LOAD,  8'd2,   32'sh0002_0000, 32'shFFFF_FFFB,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_COUNT,   9'd3, pli_pkg::KIND_LOAD,  8'd0,   32'sh0,         32'sh0,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'sh0001_8000, 32'sh0,
        1'b0, 32'sh0,         pli_pkg::ST_OK},
      '{ROW_REQUEST, 9'd0, pli_pkg::KIND_QUERY, 8'd0,   32'sh0002_0000, 32'sh0,
        1'b0, 32'sh0,         pli_pkg::ST_OK}
   };

   piecewise_linear_interpolator_unit #(
      .MAX_POINTS(MAX_POINTS),
      .VALUE_BITS(VALUE_BITS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_point_index (req_point_index),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_y_result    (rsp_y_result),
      .rsp_status      (rsp_status)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic u64_type rand64();
      return u64_type'({$urandom, $urandom});
   endfunction

   // binary search for the first breakpoint above qx, then interpolate
   function automatic lookup_result_type interpolate_at(
         input logic signed [VALUE_BITS-1:0] qx);
      lookup_result_type r;
      int                lo, hi, mid;
      longint            span, dx, dy, y_base, res;
      u64_type           mag, quot;
      r = '0;
      if (bp_count == 0) begin
         r.status = pli_pkg::ST_EMPTY;
      end else if (qx < bp_x[0] || qx > bp_x[bp_count-1]) begin
         r.status = pli_pkg::ST_RANGE;
      end else begin
         lo = 0;
         hi = bp_count - 1;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (qx < bp_x[mid]) hi = mid - 1;
            else lo = mid + 1;
         end
         if (lo >= bp_count) begin
            r.y = bp_y[bp_count-1];
         end else if (lo == 0) begin
            r.status = pli_pkg::ST_RANGE;
         end else begin
            span   = longint'(bp_x[lo]) - longint'(bp_x[lo-1]);
            dx     = longint'(qx) - longint'(bp_x[lo-1]);
            dy     = longint'(bp_y[lo]) - longint'(bp_y[lo-1]);
            y_base = longint'(bp_y[lo-1]);
            if (span <= 0 || dx < 0) begin
               r.status = pli_pkg::ST_RANGE;
            end else begin
               // truncate the magnitude, then apply the sign of the slope
               mag  = (dy < 0) ? u64_type'(-dy) : u64_type'(dy);
               quot = (mag * u64_type'(dx)) / u64_type'(span);
               res  = (dy < 0) ? y_base - longint'(quot) : y_base + longint'(quot);
               if (res > VALUE_MAX) res = VALUE_MAX;
               if (res < VALUE_MIN) res = VALUE_MIN;
               r.y = res[VALUE_BITS-1:0];
            end
         end
      end
      return r;
   endfunction

   // drive one request, hold it until taken, then update the local table or queue a prediction
   task automatic issue_request(input logic kind,
                                input logic [pli_pkg::INDEX_BITS-1:0] index,
                                input logic signed [VALUE_BITS-1:0] xv,
                                input logic signed [VALUE_BITS-1:0] yv,
                                input bit typed, input lookup_result_type typed_want);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start           = 1'b0;
         req_kind        = 1'($urandom_range(0, 1));
         req_point_index = 8'($urandom_range(0, 255));
         req_x_value     = $urandom;
         req_y_value     = $urandom;
         @(negedge clock);
      end
      start           = 1'b1;
      req_kind        = kind;
      req_point_index = index;
      req_x_value     = xv;
      req_y_value     = yv;
      do @(posedge clock); while (busy);
      requests_taken++;
      if (kind == pli_pkg::KIND_LOAD) begin
         bp_x[index] = xv;
         bp_y[index] = yv;
      end else begin
         pending_results.push_back(typed ? typed_want : interpolate_at(xv));
      end
   endtask

   // write point_count only once every response is in and loads have settled
   task automatic write_point_count(input logic [pli_pkg::CSR_BITS-1:0] value);
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LOAD_SETTLE_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      bp_count = (value > MAX_POINTS) ? MAX_POINTS : int'(value);
   endtask

   // load entries 0..n-1, nondecreasing x with random steps or fully scrambled
   task automatic load_breakpoints(input int n, input bit ordered);
      int                           scale, k;
      longint                       step_cap, xpos;
      logic signed [VALUE_BITS-1:0] xv, yv;
      lookup_result_type            none;
      none  = '0;
      scale = $urandom_range(0, 31);
      while (longint'(n) * (longint'(1) << scale) > VALUE_SPAN - 1) scale--;
      step_cap = longint'(1) << scale;
      xpos = VALUE_MIN +
             longint'(rand64() % u64_type'(VALUE_SPAN - longint'(n) * step_cap));
      for (k = 0; k < n; k++) begin
         xv = ordered ? xpos[VALUE_BITS-1:0] : $urandom;
         if ($urandom_range(0, 3) == 0) yv = int'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
         else yv = $urandom;
         issue_request(pli_pkg::KIND_LOAD, k[pli_pkg::INDEX_BITS-1:0], xv, yv, 1'b0, none);
         xpos += longint'(rand64() % u64_type'(step_cap + 1));
      end
   endtask

   // pick a point count, maybe reload a small table, then run queries
   task automatic run_segment(input bit force_top);
      int                           pick, queries, k;
      logic [pli_pkg::CSR_BITS-1:0] new_count;
      longint                       lo_x, hi_x, qx;
      lookup_result_type            none;
      none = '0;
      pick = $urandom_range(0, 99);
      if (force_top) begin
         new_count = '1;
      end else if (pick < 10) begin
         new_count = '0;
      end else if (pick < 20) begin
         new_count = 9'($urandom_range(256, 511));
      end else if (pick < 35) begin
         new_count = 9'($urandom_range(17, 255));
      end else begin
         new_count = 9'($urandom_range(1, 16));
         load_breakpoints(int'(new_count), $urandom_range(0, 4) != 0);
      end
      write_point_count(new_count);
      queries = $urandom_range(4, 12);
      for (k = 0; k < queries; k++) begin
         pick = $urandom_range(0, 99);
         qx   = longint'(int'($urandom));
         if (bp_count > 0) begin
            lo_x = bp_x[0];
            hi_x = bp_x[bp_count-1];
            if (pick < 60 && hi_x >= lo_x)
               qx = lo_x + longint'(rand64() % u64_type'(hi_x - lo_x + 1));
            else if (pick < 75)
               qx = longint'(bp_x[$urandom_range(0, bp_count - 1)])
                    + (int'($urandom_range(0, 2)) - 1);
         end
         // stray loads disturb the table between queries
         if (pick >= 90)
            issue_request(pli_pkg::KIND_LOAD, 8'($urandom_range(0, 255)), $urandom,
                          $urandom, 1'b0, none);
         else
            issue_request(pli_pkg::KIND_QUERY, 8'($urandom_range(0, 255)),
                          qx[VALUE_BITS-1:0], $urandom, 1'b0, none);
      end
   endtask

   // compare each response with the oldest prediction
   always @(posedge clock) begin : check_responses
      lookup_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response: y_result %h status %0d",
                     $time, rsp_y_result, rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_y_result !== want.y) begin
               $display("%0t: y_result mismatch: expected %h, actual %h",
                        $time, want.y, rsp_y_result);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // stop the run when nothing moves for too long
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe || csr_write_enable) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int                row, seg;
      stim_row_type      r;
      lookup_result_type want;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // walk the directed table
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         r = directed_rows[row];
         if (r.action == ROW_COUNT) begin
            write_point_count(r.count);
         end else begin
            want.y      = r.want_y;
            want.status = r.want_status;
            issue_request(r.kind, r.index, r.x, r.y, r.typed, want);
         end
      end

      // fill the whole table once so any point count reads written entries
      sender_idle_pct = 0;
      load_breakpoints(MAX_POINTS, 1'b1);

      // random segments, rotating through the sender idle patterns
      seg = 0;
      while (requests_taken < TARGET_REQUESTS) begin
         case (seg % 4)
            0: begin
               sender_idle_pct = 0;
            end
            1: begin
               sender_idle_pct = 85;
            end
            2: begin
               sender_idle_pct = 0;
            end
            default: begin
               sender_idle_pct = 7;
            end
         endcase
         run_segment(seg == 0);
         seg++;
      end

      // drain the remaining responses, then give the block time to misbehave
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
